// ===== rtl/core/five_knot_linear_curve_map_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the five knot linear curve map
// Concurrent checks that are compiled for simulation and left out of synthesis.
// ----------------------------------------------------------------------------
`ifndef FIVE_KNOT_LINEAR_CURVE_MAP_ASSERT_SVH
`define FIVE_KNOT_LINEAR_CURVE_MAP_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define FKLCM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("five_knot_linear_curve_map: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FKLCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("five_knot_linear_curve_map: next-cycle check failed");

`else

`define FKLCM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FKLCM_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/fklcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Five knot linear curve map package
// Shared widths, codes and types for the curve map and its divider.
// ----------------------------------------------------------------------------
`default_nettype none

package fklcm_pkg;

	localparam int VALUE_WIDTH = 16;
	localparam int NUM_KNOTS = 5;
	localparam int CFG_IDX_WIDTH = 3;
	localparam int SEG_SPAN = 25;

	// Segment base percent is at most 75.
	localparam int BASE_WIDTH = 7;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_WIDTH-1:0] REG_KNOT_AT_0 = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_KNOT_AT_25 = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_KNOT_AT_50 = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_KNOT_AT_75 = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_KNOT_AT_100 = 3'd4;

	// Divider geometry: the dividend is a full product of two values.
	localparam int DIV_BITS_PER_STAGE = 4;
	localparam int DIV_STAGES = (2 * VALUE_WIDTH + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
	localparam int DIV_WIDTH = DIV_STAGES * DIV_BITS_PER_STAGE;
	localparam int DSR_WIDTH = VALUE_WIDTH;

	typedef enum logic [0:0] {
		OP_FORWARD = 1'b0,
		OP_INVERSE = 1'b1
	} op_t;

	// Information that travels alongside a division.
	typedef struct packed {
		op_t                    op;
		logic [VALUE_WIDTH-1:0] lo;
		logic [BASE_WIDTH-1:0]  base;
		logic                   neg;
		logic                   below;
		logic                   flat;
	} side_t;

endpackage

`default_nettype wire

// ===== rtl/core/fklcm_if.sv =====
// ----------------------------------------------------------------------------
// Five knot linear curve map channels
// Valid/ready channels for the incoming items and the results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fklcm_in_if;
	import fklcm_pkg::*;

	logic                   valid;
	logic                   ready;
	op_t                    opcode;
	logic [VALUE_WIDTH-1:0] in_value;

	modport source (output valid, output opcode, output in_value, input ready);
	modport sink (input valid, input opcode, input in_value, output ready);
endinterface

interface fklcm_out_if;
	import fklcm_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] out_value;
	logic                   clamped;

	modport source (output valid, output out_value, output clamped, input ready);
	modport sink (input valid, input out_value, input clamped, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fklcm_div.sv =====
// ----------------------------------------------------------------------------
// Five knot linear curve map divider
// Pipelined restoring divider, a fixed number of quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fklcm_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [fklcm_pkg::DIV_WIDTH-1:0]  dividend,
	input  wire logic [fklcm_pkg::DSR_WIDTH-1:0]  divisor,
	input  wire fklcm_pkg::side_t                 in_side,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [fklcm_pkg::DIV_WIDTH-1:0]       quotient,
	output fklcm_pkg::side_t                      out_side
);
	import fklcm_pkg::*;

	// One restoring step: shift in the next dividend bit, subtract if it fits.
	function automatic logic [DSR_WIDTH+DIV_WIDTH-1:0] div_step(
		input logic [DSR_WIDTH-1:0] rem,
		input logic [DIV_WIDTH-1:0] num,
		input logic [DSR_WIDTH-1:0] dsr
	);
		logic [DSR_WIDTH:0] trial;
		logic [DSR_WIDTH:0] diff;
		trial = {rem, num[DIV_WIDTH-1]};
		diff = trial - {1'b0, dsr};
		if (trial >= {1'b0, dsr}) begin
			return {diff[DSR_WIDTH-1:0], num[DIV_WIDTH-2:0], 1'b1};
		end
		return {trial[DSR_WIDTH-1:0], num[DIV_WIDTH-2:0], 1'b0};
	endfunction

	logic                 vld_s [DIV_STAGES];
	logic [DSR_WIDTH-1:0] rem_s [DIV_STAGES];
	logic [DIV_WIDTH-1:0] num_s [DIV_STAGES];
	logic [DSR_WIDTH-1:0] dsr_s [DIV_STAGES];
	side_t                side_s [DIV_STAGES];

	logic                 stg_vld [DIV_STAGES];
	logic [DSR_WIDTH-1:0] stg_rem [DIV_STAGES];
	logic [DIV_WIDTH-1:0] stg_num [DIV_STAGES];
	logic [DSR_WIDTH-1:0] stg_dsr [DIV_STAGES];
	side_t                stg_side [DIV_STAGES];

	logic [DIV_STAGES:0]  adv;

	// A stage may load when it is empty or when the stage after it loads.
	always_comb begin
		adv[DIV_STAGES] = out_ready;
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			adv[k] = !vld_s[k] || adv[k+1];
		end
	end

	assign in_ready = adv[0];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [DSR_WIDTH-1:0] rem_nx;
		logic [DIV_WIDTH-1:0] num_nx;

		if (k == 0) begin : g_first
			assign stg_vld[k] = in_valid;
			assign stg_rem[k] = '0;
			assign stg_num[k] = dividend;
			assign stg_dsr[k] = divisor;
			assign stg_side[k] = in_side;
		end else begin : g_next
			assign stg_vld[k] = vld_s[k-1];
			assign stg_rem[k] = rem_s[k-1];
			assign stg_num[k] = num_s[k-1];
			assign stg_dsr[k] = dsr_s[k-1];
			assign stg_side[k] = side_s[k-1];
		end

		always_comb begin
			rem_nx = stg_rem[k];
			num_nx = stg_num[k];
			for (int i = 0; i < DIV_BITS_PER_STAGE; i++) begin
				{rem_nx, num_nx} = div_step(rem_nx, num_nx, stg_dsr[k]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= stg_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k] && stg_vld[k]) begin
				rem_s[k] <= rem_nx;
				num_s[k] <= num_nx;
				dsr_s[k] <= stg_dsr[k];
				side_s[k] <= stg_side[k];
			end
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign quotient = num_s[DIV_STAGES-1];
	assign out_side = side_s[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/five_knot_linear_curve_map.sv =====
// ----------------------------------------------------------------------------
// Five knot linear curve map
// Piecewise linear mapping between percent and device value, both directions.
// ----------------------------------------------------------------------------
// The block maps a value through a curve set by five device values (knots)
// at 0, 25, 50, 75 and 100 percent. Opcode forward takes a percent and gives
// knot + trunc(delta * offset / 25); opcode inverse takes a device value and
// gives base percent + trunc(25 * offset / delta), or the base percent on a
// flat segment. Quotients truncate toward zero. An inverse input below the
// first knot gives 0, and results outside the value range saturate; either
// case raises clamped. One item is accepted per cycle while the output does
// not stall. Each item passes through three front stages, the divider, which
// resolves four quotient bits per stage, and the output register, which
// offers the result on the output.
// Every stage has its own valid bit and loads when it is empty or when the
// stage after it moves on, so bubbles close up and the block keeps taking
// items while a finished result waits on the output register. The knots are
// written through the plain write port and must only change while the block
// holds no item.
// ----------------------------------------------------------------------------
`default_nettype none

`include "five_knot_linear_curve_map_assert.svh"

module five_knot_linear_curve_map (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	fklcm_in_if.sink                                   sample,
	fklcm_out_if.source                                result,
	input  wire logic                                  wr_en,
	input  wire logic [fklcm_pkg::CFG_IDX_WIDTH-1:0]   wr_index,
	input  wire logic [fklcm_pkg::VALUE_WIDTH-1:0]     wr_data
);
	import fklcm_pkg::*;

	localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;
	localparam int SUM_WIDTH = DIV_WIDTH + 2;

	// Percent at the lower end of each segment.
	function automatic logic [BASE_WIDTH-1:0] seg_base(input logic [1:0] seg);
		logic [BASE_WIDTH-1:0] b;
		case (seg)
			2'd0:    b = BASE_WIDTH'(0);
			2'd1:    b = BASE_WIDTH'(SEG_SPAN);
			2'd2:    b = BASE_WIDTH'(2 * SEG_SPAN);
			default: b = BASE_WIDTH'(3 * SEG_SPAN);
		endcase
		return b;
	endfunction

	// ------------------------------------------------------------------
	// Knot registers.
	// ------------------------------------------------------------------
	logic [VALUE_WIDTH-1:0] knot_q [NUM_KNOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KNOTS; i++) begin
				knot_q[i] <= '0;
			end
		end else if (wr_en) begin
			unique case (wr_index)
				REG_KNOT_AT_0:   knot_q[0] <= wr_data;
				REG_KNOT_AT_25:  knot_q[1] <= wr_data;
				REG_KNOT_AT_50:  knot_q[2] <= wr_data;
				REG_KNOT_AT_75:  knot_q[3] <= wr_data;
				REG_KNOT_AT_100: knot_q[4] <= wr_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stall chain. Each stage loads when empty or when its successor loads.
	// ------------------------------------------------------------------
	logic en1, en2, en3, en_out;
	logic div_in_ready, div_out_valid;
	logic v_s1, v_s2, v_s3, out_v_q;

	assign en_out = !out_v_q || result.ready;
	assign en3 = !v_s3 || div_in_ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign sample.ready = en1;

	// ------------------------------------------------------------------
	// Stage 1: segment choice and knot selection.
	// Forward compares the percent with the segment bounds, inverse compares
	// the device value with the knots, in both cases from the top down.
	// ------------------------------------------------------------------
	logic [1:0]             seg_c;
	logic [VALUE_WIDTH-1:0] lo_c, hi_c;

	op_t                    op_s1;
	logic [1:0]             seg_s1;
	logic [VALUE_WIDTH-1:0] val_s1, lo_s1, hi_s1;

	always_comb begin
		if (sample.opcode == OP_FORWARD) begin
			if (sample.in_value > VALUE_WIDTH'(3 * SEG_SPAN)) begin
				seg_c = 2'd3;
			end else if (sample.in_value > VALUE_WIDTH'(2 * SEG_SPAN)) begin
				seg_c = 2'd2;
			end else if (sample.in_value > VALUE_WIDTH'(SEG_SPAN)) begin
				seg_c = 2'd1;
			end else begin
				seg_c = 2'd0;
			end
		end else begin
			if (sample.in_value > knot_q[3]) begin
				seg_c = 2'd3;
			end else if (sample.in_value > knot_q[2]) begin
				seg_c = 2'd2;
			end else if (sample.in_value > knot_q[1]) begin
				seg_c = 2'd1;
			end else begin
				seg_c = 2'd0;
			end
		end

		case (seg_c)
			2'd0: begin
				lo_c = knot_q[0];
				hi_c = knot_q[1];
			end
			2'd1: begin
				lo_c = knot_q[1];
				hi_c = knot_q[2];
			end
			2'd2: begin
				lo_c = knot_q[2];
				hi_c = knot_q[3];
			end
			default: begin
				lo_c = knot_q[3];
				hi_c = knot_q[4];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && sample.valid) begin
			op_s1 <= sample.opcode;
			seg_s1 <= seg_c;
			val_s1 <= sample.in_value;
			lo_s1 <= lo_c;
			hi_s1 <= hi_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: segment slope as sign and magnitude, and the offset of the
	// input into its segment. An inverse input under the first knot is
	// flagged here and later forced to zero.
	// ------------------------------------------------------------------
	logic                   hi_ge_lo;
	logic [VALUE_WIDTH-1:0] dmag_c, off_c;
	logic [BASE_WIDTH-1:0]  base_c;

	op_t                    op_s2;
	logic [VALUE_WIDTH-1:0] off_s2, dmag_s2;
	side_t                  side_s2;

	always_comb begin
		hi_ge_lo = hi_s1 >= lo_s1;
		dmag_c = hi_ge_lo ? (hi_s1 - lo_s1) : (lo_s1 - hi_s1);
		base_c = seg_base(seg_s1);
		if (op_s1 == OP_FORWARD) begin
			off_c = val_s1 - VALUE_WIDTH'(base_c);
		end else begin
			off_c = val_s1 - lo_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			op_s2 <= op_s1;
			off_s2 <= off_c;
			dmag_s2 <= dmag_c;
			side_s2.op <= op_s1;
			side_s2.lo <= lo_s1;
			side_s2.base <= base_c;
			side_s2.neg <= !hi_ge_lo;
			side_s2.below <= (op_s1 == OP_INVERSE) && (seg_s1 == 2'd0) && (val_s1 < lo_s1);
			side_s2.flat <= (dmag_c == '0);
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: one shared multiplier. Forward forms slope * offset for a
	// division by the segment span, inverse forms span * offset for a
	// division by the slope.
	// ------------------------------------------------------------------
	logic [VALUE_WIDTH-1:0]   mul_a_c;
	logic [2*VALUE_WIDTH-1:0] prod_c;
	logic [DSR_WIDTH-1:0]     dsr_c;

	logic [DIV_WIDTH-1:0]     prod_s3;
	logic [DSR_WIDTH-1:0]     dsr_s3;
	side_t                    side_s3;

	always_comb begin
		if (op_s2 == OP_FORWARD) begin
			mul_a_c = dmag_s2;
			dsr_c = DSR_WIDTH'(SEG_SPAN);
		end else begin
			mul_a_c = VALUE_WIDTH'(SEG_SPAN);
			dsr_c = dmag_s2;
		end
		prod_c = (2 * VALUE_WIDTH)'(mul_a_c) * (2 * VALUE_WIDTH)'(off_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && v_s2) begin
			prod_s3 <= DIV_WIDTH'(prod_c);
			dsr_s3 <= dsr_c;
			side_s3 <= side_s2;
		end
	end

	// ------------------------------------------------------------------
	// Divider stages. A zero divisor only occurs on a flat inverse segment,
	// whose quotient is discarded below.
	// ------------------------------------------------------------------
	logic [DIV_WIDTH-1:0] quo;
	side_t                side_d;

	fklcm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (div_in_ready),
		.dividend  (prod_s3),
		.divisor   (dsr_s3),
		.in_side   (side_s3),
		.out_valid (div_out_valid),
		.out_ready (en_out),
		.quotient  (quo),
		.out_side  (side_d)
	);

	// ------------------------------------------------------------------
	// Output stage: add or subtract the quotient from the segment start,
	// then saturate into the value range.
	// ------------------------------------------------------------------
	logic signed [SUM_WIDTH-1:0] start_c, sum_c;
	logic [VALUE_WIDTH-1:0]      res_c;
	logic                        clamp_c;
	logic [VALUE_WIDTH-1:0]      out_value_q;
	logic                        clamped_q;

	always_comb begin
		if (side_d.op == OP_FORWARD) begin
			start_c = SUM_WIDTH'(side_d.lo);
		end else begin
			start_c = SUM_WIDTH'(side_d.base);
		end

		if (side_d.op == OP_INVERSE && side_d.flat) begin
			sum_c = start_c;
		end else if (side_d.neg) begin
			sum_c = start_c - SUM_WIDTH'(quo);
		end else begin
			sum_c = start_c + SUM_WIDTH'(quo);
		end

		if (side_d.below || sum_c[SUM_WIDTH-1]) begin
			res_c = '0;
			clamp_c = 1'b1;
		end else if (sum_c[SUM_WIDTH-2:VALUE_WIDTH] != '0) begin
			res_c = VALUE_MAX;
			clamp_c = 1'b1;
		end else begin
			res_c = sum_c[VALUE_WIDTH-1:0];
			clamp_c = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && div_out_valid) begin
			out_value_q <= res_c;
			clamped_q <= clamp_c;
		end
	end

	assign result.valid = out_v_q;
	assign result.out_value = out_value_q;
	assign result.clamped = clamped_q;

	// ------------------------------------------------------------------
	// Checks.
	// ------------------------------------------------------------------

	// A saturated result sits at one end of the range.
	`FKLCM_ASSERT_SAME(a_clamp_at_limit, clk, arst_n, result.valid && result.clamped, result.out_value == '0 || result.out_value == VALUE_MAX)

	// Stage 1 keeps its item while the stage after it cannot load.
	`FKLCM_ASSERT_NEXT(a_s1_holds, clk, arst_n, v_s1 && !en2, v_s1 && $stable(val_s1) && $stable(op_s1))

	// An inverse input under the first knot leaves as a clamped zero.
	`FKLCM_ASSERT_NEXT(a_below_zero, clk, arst_n, div_out_valid && en_out && side_d.below, result.valid && result.clamped && result.out_value == '0)

	// A flat inverse segment gives its base percent.
	`FKLCM_ASSERT_NEXT(a_flat_base, clk, arst_n, div_out_valid && en_out && side_d.op == OP_INVERSE && side_d.flat && !side_d.below, result.valid && !result.clamped && result.out_value == VALUE_WIDTH'($past(side_d.base)))

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// Five knot linear curve map testbench
// Pushes percent and device value conversions through a series of knot
// curves, predicts every result inside the bench and compares each result
// transfer, field by field, with the oldest prediction still awaited.
// ----------------------------------------------------------------------------
module tb_top;
	import fklcm_pkg::*;

	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 9;
	// Pipeline depth: the front stages, the divider stages and the output register.
	localparam int PIPE_LATENCY = 4 + DIV_STAGES;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DIRECTED_ROWS = 25;
	localparam int DIRECTED_CURVES_N = 5;
	localparam int RANDOM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int LIGHT_IDLE_PCT = 8;
	localparam int HEAVY_IDLE_PCT = 59;
	localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = '1;

	// Knot 0 (device value at zero percent) sits at index 0.
	typedef logic [0:NUM_KNOTS-1][VALUE_WIDTH-1:0] knot_set_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic                   clamped;
	} mapping_t;

	// One row of the directed table. Where typed is set the expected result
	// is written into the row; otherwise the predictor supplies it.
	typedef struct packed {
		logic [2:0]             curve;
		op_t                    op;
		logic [VALUE_WIDTH-1:0] value;
		logic                   typed;
		mapping_t               want;
	} probe_t;

	typedef enum {
		CURVE_RISING,
		CURVE_FALLING,
		CURVE_ANY,
		CURVE_NARROW,
		CURVE_EXTREME
	} curve_style_t;

	localparam logic [CFG_IDX_WIDTH-1:0] KNOT_REG [NUM_KNOTS] = '{
		REG_KNOT_AT_0, REG_KNOT_AT_25, REG_KNOT_AT_50, REG_KNOT_AT_75, REG_KNOT_AT_100
	};

	// Curves used by the directed table: reset state, a rising curve, a
	// falling curve, one made only of the extremes with a flat stretch, and
	// one so steep that the inverse map runs off the top of the range.
	localparam knot_set_t DIRECTED_CURVES [DIRECTED_CURVES_N] = '{
		'{16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
		'{16'd1000, 16'd2000, 16'd4000, 16'd8000, 16'd16000},
		'{16'd60000, 16'd40000, 16'd30000, 16'd20000, 16'd10000},
		'{16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF},
		'{16'd100, 16'd101, 16'd102, 16'd103, 16'd104}
	};

	localparam probe_t DIRECTED_PROBES [DIRECTED_ROWS] = '{
		// Straight after reset every knot is zero, so every segment is flat.
		'{3'd0, OP_FORWARD, 16'd0, 1'b1, '{16'd0, 1'b0}},
		'{3'd0, OP_FORWARD, 16'hFFFF, 1'b1, '{16'd0, 1'b0}},
		'{3'd0, OP_INVERSE, 16'd0, 1'b1, '{16'd0, 1'b0}},
		'{3'd0, OP_INVERSE, 16'hFFFF, 1'b1, '{16'd75, 1'b0}},
		// Rising curve: knee points, extrapolation past 100 percent,
		// saturation at the top and an inverse input below the first knot.
		'{3'd1, OP_FORWARD, 16'd0, 1'b1, '{16'd1000, 1'b0}},
		'{3'd1, OP_FORWARD, 16'd25, 1'b1, '{16'd2000, 1'b0}},
		'{3'd1, OP_FORWARD, 16'd37, 1'b0, '0},
		'{3'd1, OP_FORWARD, 16'd100, 1'b1, '{16'd16000, 1'b0}},
		'{3'd1, OP_FORWARD, 16'd101, 1'b0, '0},
		'{3'd1, OP_FORWARD, 16'hFFFF, 1'b1, '{16'hFFFF, 1'b1}},
		'{3'd1, OP_INVERSE, 16'd500, 1'b1, '{16'd0, 1'b1}},
		'{3'd1, OP_INVERSE, 16'd1000, 1'b1, '{16'd0, 1'b0}},
		'{3'd1, OP_INVERSE, 16'd3000, 1'b0, '0},
		'{3'd1, OP_INVERSE, 16'hFFFF, 1'b0, '0},
		// Falling curve: both directions can run below zero here.
		'{3'd2, OP_FORWARD, 16'd60, 1'b0, '0},
		'{3'd2, OP_FORWARD, 16'hFFFF, 1'b1, '{16'd0, 1'b1}},
		'{3'd2, OP_INVERSE, 16'd0, 1'b1, '{16'd0, 1'b1}},
		'{3'd2, OP_INVERSE, 16'hFFFF, 1'b1, '{16'd0, 1'b1}},
		// Extremes: full-scale deltas and a flat segment from 25 to 50 percent.
		'{3'd3, OP_FORWARD, 16'd25, 1'b1, '{16'hFFFF, 1'b0}},
		'{3'd3, OP_FORWARD, 16'd50, 1'b1, '{16'hFFFF, 1'b0}},
		'{3'd3, OP_INVERSE, 16'hFFFF, 1'b1, '{16'd100, 1'b0}},
		'{3'd3, OP_INVERSE, 16'd1, 1'b0, '0},
		// Steep curve: a delta of one makes the inverse quotient huge.
		'{3'd4, OP_INVERSE, 16'hFFFF, 1'b1, '{16'hFFFF, 1'b1}},
		'{3'd4, OP_INVERSE, 16'd102, 1'b0, '0},
		'{3'd4, OP_FORWARD, 16'hFFFF, 1'b0, '0}
	};

	// Idling moves from a stalling receiver to a lazy sender and then to none.
	localparam curve_style_t PHASE_STYLE [RANDOM_PHASES] = '{
		CURVE_RISING, CURVE_FALLING, CURVE_ANY, CURVE_NARROW, CURVE_EXTREME, CURVE_ANY
	};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     wr_en;
	logic [CFG_IDX_WIDTH-1:0] wr_index;
	logic [VALUE_WIDTH-1:0]   wr_data;

	fklcm_in_if  sample_ch ();
	fklcm_out_if result_ch ();

	// Knots as the block should hold them, updated as each write is issued.
	knot_set_t curve_knots;
	// Results predicted for accepted items, oldest first.
	mapping_t  awaited_results [$];

	int send_gap_pct;
	int recv_stall_pct;
	int failures;
	int compared;
	int cycles_run;
	int directed_count;
	int random_count;
	int settings_count;

	five_knot_linear_curve_map u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample   (sample_ch),
		.result   (result_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #HALF_PERIOD clk = ~clk;

	// Expected mapping of one item through the current knots. Segment choice,
	// truncating quotients and saturation follow the block's definition; all
	// arithmetic is done in 64 bits so that nothing wraps before saturation.
	function automatic mapping_t map_through_curve(op_t op, logic [VALUE_WIDTH-1:0] x);
		int       seg;
		longint   v;
		longint   lo;
		longint   hi;
		longint   r;
		mapping_t m;
		v = longint'(x);
		if (op == OP_FORWARD) begin
			if (v > 3 * SEG_SPAN) seg = 3;
			else if (v > 2 * SEG_SPAN) seg = 2;
			else if (v > SEG_SPAN) seg = 1;
			else seg = 0;
			lo = longint'(curve_knots[seg]);
			hi = longint'(curve_knots[seg + 1]);
			if (hi >= lo) r = lo + (hi - lo) * (v - seg * SEG_SPAN) / SEG_SPAN;
			else r = lo - (lo - hi) * (v - seg * SEG_SPAN) / SEG_SPAN;
		end else begin
			if (v > longint'(curve_knots[3])) seg = 3;
			else if (v > longint'(curve_knots[2])) seg = 2;
			else if (v > longint'(curve_knots[1])) seg = 1;
			else seg = 0;
			lo = longint'(curve_knots[seg]);
			hi = longint'(curve_knots[seg + 1]);
			if (seg == 0 && v < lo) begin
				m.value = '0;
				m.clamped = 1'b1;
				return m;
			end
			if (hi == lo) r = seg * SEG_SPAN;
			else if (hi > lo) r = seg * SEG_SPAN + SEG_SPAN * (v - lo) / (hi - lo);
			else r = seg * SEG_SPAN - SEG_SPAN * (v - lo) / (lo - hi);
		end
		if (r < 0) begin
			m.value = '0;
			m.clamped = 1'b1;
		end else if (r > longint'(VALUE_MAX)) begin
			m.value = VALUE_MAX;
			m.clamped = 1'b1;
		end else begin
			m.value = r[VALUE_WIDTH-1:0];
			m.clamped = 1'b0;
		end
		return m;
	endfunction

	// Random knot set of the given shape.
	function automatic knot_set_t draw_curve(curve_style_t style);
		int        vals [$];
		int        base;
		knot_set_t ks;
		base = int'($urandom_range(int'(VALUE_MAX) - 3));
		for (int i = 0; i < NUM_KNOTS; i++) begin
			case (style)
				CURVE_NARROW: vals.push_back(base + int'($urandom_range(3)));
				CURVE_EXTREME: vals.push_back($urandom_range(1) ? int'(VALUE_MAX) : 0);
				default: vals.push_back(int'($urandom_range(int'(VALUE_MAX))));
			endcase
		end
		if (style == CURVE_RISING) vals.sort();
		else if (style == CURVE_FALLING) vals.rsort();
		for (int i = 0; i < NUM_KNOTS; i++) ks[i] = VALUE_WIDTH'(vals[i]);
		return ks;
	endfunction

	// Random input value. Forward percents mostly stay within 0..110 with the
	// knee points favoured, else in 101..1000 or anywhere; inverse values
	// mostly lie in the knots' span or next to a knot, else anywhere.
	function automatic logic [VALUE_WIDTH-1:0] draw_input(op_t op);
		int pick;
		int k;
		int lo_k;
		int hi_k;
		pick = int'($urandom_range(9));
		lo_k = int'(VALUE_MAX);
		hi_k = 0;
		for (int i = 0; i < NUM_KNOTS; i++) begin
			if (int'(curve_knots[i]) < lo_k) lo_k = int'(curve_knots[i]);
			if (int'(curve_knots[i]) > hi_k) hi_k = int'(curve_knots[i]);
		end
		if (op == OP_FORWARD) begin
			if (pick < 7) return VALUE_WIDTH'($urandom_range(4 * SEG_SPAN + 10));
			if (pick == 7) return VALUE_WIDTH'($urandom);
			if (pick == 8) return VALUE_WIDTH'(int'($urandom_range(4)) * SEG_SPAN
				+ int'($urandom_range(1)));
			return VALUE_WIDTH'($urandom_range(1000, 4 * SEG_SPAN + 1));
		end
		if (pick < 6) return VALUE_WIDTH'($urandom_range(hi_k, lo_k));
		if (pick == 6) begin
			k = int'(curve_knots[$urandom_range(NUM_KNOTS - 1)]) + int'($urandom_range(2)) - 1;
			if (k < 0) k = 0;
			if (k > int'(VALUE_MAX)) k = int'(VALUE_MAX);
			return VALUE_WIDTH'(k);
		end
		return VALUE_WIDTH'($urandom);
	endfunction

	// Writes all five knots in index order, then one write to an index past
	// the last knot register, which the block must ignore.
	task automatic program_curve(knot_set_t ks);
		for (int i = 0; i < NUM_KNOTS; i++) begin
			wr_en <= 1'b1;
			wr_index <= KNOT_REG[i];
			wr_data <= ks[i];
			curve_knots[i] = ks[i];
			@(posedge clk);
		end
		wr_index <= REG_KNOT_AT_100 + CFG_IDX_WIDTH'(1 + $urandom_range(2));
		wr_data <= VALUE_WIDTH'($urandom);
		@(posedge clk);
		wr_en <= 1'b0;
		settings_count++;
	endtask

	// Holds off new items until every awaited result has come back, then
	// lets the pipeline run empty for its full latency.
	task automatic settle_pipeline();
		sample_ch.valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	// Offers one item, with a random number of idle cycles first, and
	// returns at the edge where the transfer takes place. Valid is left high
	// so that back-to-back items need no second assignment in one step.
	task automatic feed_sample(op_t op, logic [VALUE_WIDTH-1:0] x);
		while ($urandom_range(99) < send_gap_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.opcode <= op;
		sample_ch.in_value <= x;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
	endtask

	// The receiver accepts results at random; the stall rate changes by phase.
	initial begin : result_receiver
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Every result transfer is held against the oldest awaited prediction.
	always @(posedge clk) begin : result_checker
		mapping_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (awaited_results.size() == 0) begin
				$error("result transfer with nothing awaited: out_value %0d clamped %0b",
					result_ch.out_value, result_ch.clamped);
				failures++;
			end else begin
				want = awaited_results.pop_front();
				compared++;
				if (result_ch.out_value !== want.value) begin
					$error("out_value mismatch: expected %0d, actual %0d",
						want.value, result_ch.out_value);
					failures++;
				end
				if (result_ch.clamped !== want.clamped) begin
					$error("clamped mismatch: expected %0b, actual %0b",
						want.clamped, result_ch.clamped);
					failures++;
				end
			end
		end
	end

	// A hung handshake or a lost result ends the run here.
	initial begin : watchdog
		for (cycles_run = 0; cycles_run < CYCLE_LIMIT; cycles_run++) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus
		probe_t                 row;
		logic [2:0]             live_curve;
		op_t                    op;
		logic [VALUE_WIDTH-1:0] x;

		// Every input of the block is known from the very first instant.
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = REG_KNOT_AT_0;
		wr_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.opcode = OP_FORWARD;
		sample_ch.in_value = '0;
		curve_knots = '0;
		failures = 0;
		compared = 0;
		directed_count = 0;
		random_count = 0;
		settings_count = 0;
		// First stretch: the sender rarely idles while the receiver stalls a lot.
		send_gap_pct = LIGHT_IDLE_PCT;
		recv_stall_pct = HEAVY_IDLE_PCT;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. The first rows run on the reset knots; each change
		// of curve waits for the pipeline to empty before the knots are written.
		live_curve = 3'd0;
		for (int n = 0; n < DIRECTED_ROWS; n++) begin
			row = DIRECTED_PROBES[n];
			if (row.curve != live_curve) begin
				settle_pipeline();
				program_curve(DIRECTED_CURVES[row.curve]);
				live_curve = row.curve;
			end
			feed_sample(row.op, row.value);
			awaited_results.push_back(row.typed ? row.want : map_through_curve(row.op, row.value));
			directed_count++;
		end

		// Random phases, each on a freshly drawn curve. Both directions are
		// equally likely; the idle pattern swaps sides after two phases and
		// is switched off for the last two.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			settle_pipeline();
			program_curve(draw_curve(PHASE_STYLE[phase]));
			send_gap_pct = (phase < 2) ? LIGHT_IDLE_PCT : (phase < 4) ? HEAVY_IDLE_PCT : 0;
			recv_stall_pct = (phase < 2) ? HEAVY_IDLE_PCT : (phase < 4) ? LIGHT_IDLE_PCT : 0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				op = $urandom_range(1) ? OP_INVERSE : OP_FORWARD;
				x = draw_input(op);
				feed_sample(op, x);
				awaited_results.push_back(map_through_curve(op, x));
				random_count++;
			end
		end

		// Wait for the last results and give any stray transfer time to show.
		settle_pipeline();

		$display("Ran %0d directed and %0d random conversions over %0d knot settings.",
			directed_count, random_count, settings_count);
		$display("Compared %0d results in both directions under sender and receiver stalls.",
			compared);
		if (failures == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// ===== five_knot_linear_curve_map.f =====
+incdir+rtl/core
rtl/core/fklcm_pkg.sv
rtl/core/fklcm_if.sv
rtl/core/fklcm_div.sv
rtl/core/five_knot_linear_curve_map.sv
verif/tb_top.sv
